### hdl/heq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer package
// Shared default sizes and the pixel width of the histogram equalizer.
// ----------------------------------------------------------------------------
package heq_pkg;

    // Default pixel budget of one image and number of gray levels.
    localparam int DEF_MAX_PIXELS = 262144;
    localparam int DEF_LEVELS     = 256;

    // Width of the pixel and of one mapping table entry.
    localparam int PIXEL_W = 8;

endpackage

### hdl/histogram_equalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer
// Two-pass 8-bit grayscale equalization over a histogram memory and a
// mapping table memory.
// ----------------------------------------------------------------------------
// A remap request gives its result strobe in the cycle after it is
// accepted; a counting request gives no result. Both passes take one
// request per cycle while busy is low, the bin read-modify-write
// forwarding back-to-back hits. After the last counting request busy
// stays high for the table build, which runs the bit-serial divider.
// After reset busy stays high for a clearing pass over all LEVELS entries.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module histogram_equalizer #(
    parameter int MAX_PIXELS = heq_pkg::DEF_MAX_PIXELS,
    parameter int LEVELS     = heq_pkg::DEF_LEVELS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         kind,
    input  logic [heq_pkg::PIXEL_W-1:0]  pixel,
    input  logic                         last,
    output logic                         result_strobe,
    output logic [heq_pkg::PIXEL_W-1:0]  pixel_out
);
    import heq_pkg::*;

    // Bin counts and the pixel total never exceed MAX_PIXELS.
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int LW = $clog2(LEVELS);
    // Width of the division numerator 2*(LEVELS-1)*cdf + N.
    localparam int RW = CW + LW + 1;
    localparam int QW = (LW > PIXEL_W) ? LW : PIXEL_W;

    localparam logic [LW-1:0] LAST_IDX  = LW'(LEVELS - 1);
    localparam logic [LW:0]   SCALE     = (LW + 1)'(2 * (LEVELS - 1));
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_PIXELS);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN,
        ST_READ,
        ST_ACC,
        ST_MUL,
        ST_DIV,
        ST_WAIT,
        ST_WRMAP
    } state_t;

    state_t         state_reg;

    // Memories: histogram bins and the mapping table.
    logic [CW-1:0]      bin_mem [LEVELS];
    logic [PIXEL_W-1:0] map_mem [LEVELS];
    logic [CW-1:0]      bin_rdata_reg;
    logic [PIXEL_W-1:0] map_rdata_reg;

    // Counting stage, write-back forwarding and build registers.
    logic               s1_valid_reg;
    logic [LW-1:0]      s1_idx_reg;
    logic               fw_valid_reg;
    logic [LW-1:0]      fw_idx_reg;
    logic [CW-1:0]      fw_val_reg;
    logic [CW-1:0]      total_reg;
    logic [CW-1:0]      cdf_reg;
    logic [RW-1:0]      prod_reg;
    logic [LW-1:0]      idx_reg;
    logic               strobe_reg;

    logic               accept;
    logic [LW-1:0]      pix_idx;
    logic [CW-1:0]      bin_cur;
    logic               count_we;
    logic               bin_we;
    logic [LW-1:0]      bin_waddr;
    logic [CW-1:0]      bin_wdata;
    logic               bin_re;
    logic [LW-1:0]      bin_raddr;
    logic               map_we;
    logic [PIXEL_W-1:0] map_wdata;
    logic [RW-1:0]      prod;
    logic               div_start;
    logic               div_done;
    logic [QW-1:0]      div_quot;

    assign busy   = (state_reg != ST_RUN);
    assign accept = start && !busy;

    // Pixel values beyond the level range fold onto the top level.
    always_comb
    begin
        if ({24'd0, pixel} >= 32'(LEVELS))
        begin
            pix_idx = LAST_IDX;
        end
        else
        begin
            pix_idx = LW'(pixel);
        end
    end

    // The bin read was launched in the cycle before its write; when the previous
    // cycle wrote the same bin, the memory data is stale and is bypassed.
    assign bin_cur  = (fw_valid_reg && (fw_idx_reg == s1_idx_reg)) ? fw_val_reg
                                                                   : bin_rdata_reg;
    // A saturated total drops the pixel entirely so the bins still add up.
    assign count_we = s1_valid_reg && (total_reg < MAX_COUNT);

    // Bin memory ports. The clearing pass, the counting stage and the build
    // walk never overlap in time.
    always_comb
    begin
        bin_we    = 1'b0;
        bin_waddr = s1_idx_reg;
        bin_wdata = bin_cur + 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                bin_we    = 1'b1;
                bin_waddr = idx_reg;
                bin_wdata = '0;
            end
            ST_ACC:
            begin
                bin_we    = 1'b1;
                bin_waddr = idx_reg;
                bin_wdata = '0;
            end
            default:
            begin
                bin_we = count_we;
            end
        endcase
    end

    assign bin_re    = (accept && !kind) || (state_reg == ST_READ);
    assign bin_raddr = (state_reg == ST_READ) ? idx_reg : pix_idx;

    assign map_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRMAP);
    // An empty total cannot reach the build, but it maps everything to zero.
    assign map_wdata = ((state_reg == ST_CLEAR) || (total_reg == '0)) ? '0
                                                                      : div_quot[PIXEL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (bin_we)
        begin
            bin_mem[bin_waddr] <= bin_wdata;
        end
        if (bin_re)
        begin
            bin_rdata_reg <= bin_mem[bin_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[idx_reg] <= map_wdata;
        end
        if (accept && kind)
        begin
            map_rdata_reg <= map_mem[pix_idx];
        end
    end

    // Scaled cumulative count, 2*(LEVELS-1)*cdf.
    assign prod = {{(LW + 1){1'b0}}, cdf_reg} * {{CW{1'b0}}, SCALE};

    assign div_start = (state_reg == ST_DIV);

    heq_div #(
        .MAX_PIXELS (MAX_PIXELS),
        .LEVELS     (LEVELS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (prod_reg + RW'(total_reg)),
        .denom ({total_reg, 1'b0}),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Sequencer: clearing pass, counting and remap service, table build.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_idx_reg   <= '0;
            fw_valid_reg <= 1'b0;
            fw_idx_reg   <= '0;
            fw_val_reg   <= '0;
            total_reg    <= '0;
            cdf_reg      <= '0;
            prod_reg     <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && !kind;
            s1_idx_reg   <= pix_idx;
            fw_valid_reg <= count_we;
            fw_idx_reg   <= s1_idx_reg;
            fw_val_reg   <= bin_cur + 1'b1;
            strobe_reg   <= accept && kind;
            if (count_we)
            begin
                total_reg <= total_reg + 1'b1;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_RUN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_RUN:
                begin
                    if (accept && !kind && last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    // The last pixel is written back in this cycle.
                    idx_reg   <= '0;
                    cdf_reg   <= '0;
                    state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    cdf_reg   <= cdf_reg + bin_rdata_reg;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    prod_reg  <= prod;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_WRMAP;
                    end
                end
                ST_WRMAP:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg   <= '0;
                        cdf_reg   <= '0;
                        total_reg <= '0;
                        state_reg <= ST_RUN;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                default:
                begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    assign result_strobe = strobe_reg;
    assign pixel_out     = map_rdata_reg;

    // A result only ever answers a remap request of the cycle before.
    a_strobe_from_remap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(start && !busy && kind))
        else $error("result strobe without a remap request");

    // The last counting request always starts a table build.
    a_last_starts_build: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !kind && last) |=> (busy && (state_reg == ST_DRAIN)))
        else $error("last counting request did not start the build");

    // The pixel total saturates and never passes the budget.
    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= MAX_COUNT)
        else $error("pixel total beyond its maximum");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_WAIT))
        else $error("divider finished outside the wait state");

endmodule

### hdl/heq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer divider
// Restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module heq_div #(
    parameter int MAX_PIXELS = heq_pkg::DEF_MAX_PIXELS,
    parameter int LEVELS     = heq_pkg::DEF_LEVELS
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic [$clog2(MAX_PIXELS+1)+$clog2(LEVELS):0]      numer,
    input  logic [$clog2(MAX_PIXELS+1):0]                     denom,
    output logic                                              done,
    output logic [(($clog2(LEVELS) > heq_pkg::PIXEL_W) ?
                   $clog2(LEVELS) : heq_pkg::PIXEL_W)-1:0]   quot
);
    import heq_pkg::*;

    localparam int CW  = $clog2(MAX_PIXELS + 1);
    localparam int LW  = $clog2(LEVELS);
    localparam int RW  = CW + LW + 1;
    localparam int QW  = (LW > PIXEL_W) ? LW : PIXEL_W;
    localparam int CNW = $clog2(LW + 1);

    logic [RW-1:0]  rem_reg;
    logic [RW-1:0]  dsr_reg;
    logic [QW-1:0]  q_reg;
    logic [CNW-1:0] cnt_reg;
    logic           done_reg;
    logic           fits;

    // The quotient is known to stay below LEVELS, so the divisor starts
    // aligned to the top quotient bit.
    assign fits = (rem_reg >= dsr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNW'(LW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= numer;
            dsr_reg <= RW'({1'b0, denom}) << (LW - 1);
            q_reg   <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsr_reg;
            end
            dsr_reg <= dsr_reg >> 1;
            q_reg   <= {q_reg[QW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer testbench
// Feeds counting and remap requests to the equalizer, keeps its own copy of
// the histogram, pixel total and mapping table, and checks each remapped
// pixel against that copy or a value typed in the directed table, which
// comes first; random images with random gaps follow.
// ----------------------------------------------------------------------------
module tb_top;

    import heq_pkg::*;

    localparam int     MAX_PIX      = DEF_MAX_PIXELS;
    localparam int     NUM_LEVELS   = DEF_LEVELS;
    localparam int     RANDOM_ITEMS = 750;
    localparam int     DIR_ROWS     = 24;
    // The slowest correct run, table builds included, stays several times
    // under this limit.
    localparam longint CYCLE_LIMIT  = 5_000_000;
    // A remap result comes in the cycle after its request is accepted; wait a little longer.
    localparam int     TAIL_CYCLES  = 4;

    // Request kinds as the kind port encodes them.
    typedef enum logic {
        KIND_COUNT = 1'b0,
        KIND_REMAP = 1'b1
    } req_kind_e;

    // One row of the directed table. Where want_typed is set, the expected
    // pixel is written in the row; otherwise it comes from the local model.
    typedef struct {
        req_kind_e            kind;
        logic [PIXEL_W-1:0]   pixel;
        logic                 last;
        bit                   want_typed;
        logic [PIXEL_W-1:0]   want;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               kind;
    logic [PIXEL_W-1:0] pixel;
    logic               last;
    logic               result_strobe;
    logic [PIXEL_W-1:0] pixel_out;

    // Local copy of the block's state.
    logic [18:0]        hist_bins [NUM_LEVELS];
    logic [18:0]        pixel_count;
    logic [PIXEL_W-1:0] map_lut [NUM_LEVELS];

    // Equalized pixels still owed by the block, oldest first.
    logic [PIXEL_W-1:0] expected_pixels [$];
    logic [PIXEL_W-1:0] oldest_pixel;

    dir_row_t           dir_rows [DIR_ROWS];

    int                 error_count;
    int                 request_count;
    int                 result_count;
    int                 build_count;
    longint             cycle_count;

    histogram_equalizer #(
        .MAX_PIXELS (MAX_PIX),
        .LEVELS     (NUM_LEVELS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .pixel         (pixel),
        .last          (last),
        .result_strobe (result_strobe),
        .pixel_out     (pixel_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Pixels at or above the number of levels fold onto the top level.
    function automatic int unsigned level_of(input logic [PIXEL_W-1:0] p);
        if (p >= NUM_LEVELS)
            return NUM_LEVELS - 1;
        return p;
    endfunction

    // Walk the bins, build the running count and fill the mapping table with
    // the rounded value of cdf * (levels - 1) / total, done in integers. The
    // histogram and the total then start over for the next image.
    task automatic rebuild_map_lut();
        longint unsigned total;
        longint unsigned cdf;
        longint unsigned scaled;
        total = pixel_count;
        cdf = 0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            cdf += hist_bins[i];
            if (total == 0)
                map_lut[i] = '0;
            else
            begin
                scaled = (2 * (NUM_LEVELS - 1) * cdf + total) / (2 * total);
                map_lut[i] = scaled[PIXEL_W-1:0];
            end
        end
        for (int i = 0; i < NUM_LEVELS; i++)
            hist_bins[i] = '0;
        pixel_count = '0;
        build_count++;
    endtask

    // Apply one accepted request to the local state. A remap request yields
    // the table entry of its pixel; a counting request yields nothing.
    task automatic equalize_step(input req_kind_e k, input logic [PIXEL_W-1:0] p,
                                 input logic l, output bit has_res,
                                 output logic [PIXEL_W-1:0] res);
        int unsigned idx;
        idx = level_of(p);
        has_res = 1'b0;
        res = '0;
        if (k == KIND_REMAP)
        begin
            // The last flag means nothing on a remap request.
            has_res = 1'b1;
            res = map_lut[idx];
        end
        else
        begin
            // Once the total reaches the budget, further pixels are dropped so
            // the bins keep summing to the total.
            if (pixel_count < MAX_PIX)
            begin
                hist_bins[idx] = hist_bins[idx] + 1'b1;
                pixel_count = pixel_count + 1'b1;
            end
            if (l)
                rebuild_map_lut();
        end
    endtask

    // Hold start low for gap cycles, then present the request and keep it up
    // until an edge where busy is low. The edge that accepts it is the one
    // the task returns on, so the next call can raise or keep start at once.
    task automatic send_request(input req_kind_e k, input logic [PIXEL_W-1:0] p,
                                input logic l, input int gap, input bit typed,
                                input logic [PIXEL_W-1:0] typed_val);
        bit                 has_res;
        logic [PIXEL_W-1:0] res;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        kind  <= k;
        pixel <= p;
        last  <= l;
        do
            @(posedge clk);
        while (busy);
        request_count++;
        equalize_step(k, p, l, has_res, res);
        if (has_res)
            expected_pixels.push_back(typed ? typed_val : res);
    endtask

    // Stop sending until every owed pixel has come back.
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_pixels.size() != 0);
    endtask

    // Result checker. Results cannot be held off, so every strobe is taken
    // at the edge that closes its cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("pixel_out: no result expected, actual %0d", pixel_out);
                error_count++;
            end
            else
            begin
                oldest_pixel = expected_pixels.pop_front();
                result_count++;
                if (pixel_out !== oldest_pixel)
                begin
                    $error("pixel_out: expected %0d, actual %0d", oldest_pixel, pixel_out);
                    error_count++;
                end
            end
        end
    end

    // Watchdog against a hung block.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int          random_sent;
        int          n_pix;
        int          n_remap;
        int          lo;
        int          hi;
        int          shape;
        bit          no_idle;
        bit          end_flag;
        logic [7:0]  px;

        error_count       = 0;
        request_count     = 0;
        result_count      = 0;
        build_count       = 0;
        cycle_count       = 0;
        random_sent       = 0;

        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            hist_bins[i] = '0;
            map_lut[i]   = '0;
        end
        pixel_count = '0;

        // Directed table. Before any build the table reads zero everywhere.
        // An image of one dark and one bright pixel maps every level below
        // the top to half scale and the top level to full scale. A single
        // pixel image maps levels below it to zero and the rest to full scale.
        dir_rows[0]  = '{KIND_REMAP, 8'd0,   1'b0, 1'b1, 8'd0};
        dir_rows[1]  = '{KIND_REMAP, 8'd255, 1'b0, 1'b1, 8'd0};
        dir_rows[2]  = '{KIND_REMAP, 8'd128, 1'b1, 1'b1, 8'd0};
        dir_rows[3]  = '{KIND_COUNT, 8'd0,   1'b0, 1'b0, 8'd0};
        dir_rows[4]  = '{KIND_COUNT, 8'd255, 1'b1, 1'b0, 8'd0};
        dir_rows[5]  = '{KIND_REMAP, 8'd0,   1'b0, 1'b1, 8'd128};
        dir_rows[6]  = '{KIND_REMAP, 8'd255, 1'b0, 1'b1, 8'd255};
        dir_rows[7]  = '{KIND_REMAP, 8'd100, 1'b1, 1'b1, 8'd128};
        dir_rows[8]  = '{KIND_COUNT, 8'd7,   1'b1, 1'b0, 8'd0};
        dir_rows[9]  = '{KIND_REMAP, 8'd6,   1'b0, 1'b1, 8'd0};
        dir_rows[10] = '{KIND_REMAP, 8'd7,   1'b0, 1'b1, 8'd255};
        dir_rows[11] = '{KIND_REMAP, 8'd255, 1'b0, 1'b1, 8'd255};
        dir_rows[12] = '{KIND_COUNT, 8'd0,   1'b0, 1'b0, 8'd0};
        dir_rows[13] = '{KIND_COUNT, 8'd85,  1'b0, 1'b0, 8'd0};
        dir_rows[14] = '{KIND_COUNT, 8'd170, 1'b0, 1'b0, 8'd0};
        dir_rows[15] = '{KIND_COUNT, 8'd170, 1'b1, 1'b0, 8'd0};
        dir_rows[16] = '{KIND_REMAP, 8'd0,   1'b0, 1'b0, 8'd0};
        dir_rows[17] = '{KIND_REMAP, 8'd85,  1'b0, 1'b0, 8'd0};
        dir_rows[18] = '{KIND_REMAP, 8'd170, 1'b0, 1'b0, 8'd0};
        dir_rows[19] = '{KIND_REMAP, 8'd169, 1'b0, 1'b0, 8'd0};
        dir_rows[20] = '{KIND_REMAP, 8'd171, 1'b1, 1'b0, 8'd0};
        dir_rows[21] = '{KIND_REMAP, 8'd255, 1'b0, 1'b0, 8'd0};
        dir_rows[22] = '{KIND_REMAP, 8'd170, 1'b0, 1'b0, 8'd0};
        dir_rows[23] = '{KIND_REMAP, 8'd0,   1'b0, 1'b0, 8'd0};

        // All inputs are known from time zero. Reset is held low at the start;
        // the block then clears its memories and shows busy meanwhile.
        rst_n <= 1'b0;
        start <= 1'b0;
        kind  <= KIND_COUNT;
        pixel <= '0;
        last  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_request(dir_rows[i].kind, dir_rows[i].pixel, dir_rows[i].last,
                         $urandom_range(0, 7), dir_rows[i].want_typed, dir_rows[i].want);

        // Hold off once until the directed results are all in.
        wait_drained();

        // Random images: a counting pass of random shape, then a burst of
        // remaps. Some images stray: remaps slip into the counting pass, or
        // the last flag is left off so the image runs into the next one.
        while (random_sent < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                wait_drained();
            n_pix = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 300)
                                                : $urandom_range(1, 48);
            shape = $urandom_range(0, 3);
            lo = $urandom_range(0, 255);
            hi = lo + $urandom_range(0, 255 - lo);
            end_flag = ($urandom_range(0, 9) != 0);
            for (int j = 0; j < n_pix; j++)
            begin
                case (shape)
                    0: px = 8'($urandom_range(0, 255));
                    1: px = 8'($urandom_range(lo, hi));
                    2: px = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                    default: px = 8'(lo);
                endcase
                if ($urandom_range(0, 15) == 0)
                begin
                    send_request(KIND_REMAP, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)),
                                 no_idle ? 0 : $urandom_range(0, 7), 1'b0, '0);
                    random_sent++;
                end
                send_request(KIND_COUNT, px, end_flag && (j == n_pix - 1),
                             no_idle ? 0 : $urandom_range(0, 7), 1'b0, '0);
                random_sent++;
            end
            n_remap = $urandom_range(2, 40);
            for (int j = 0; j < n_remap; j++)
            begin
                px = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(lo, hi));
                send_request(KIND_REMAP, px, 1'($urandom_range(0, 1)),
                             no_idle ? 0 : $urandom_range(0, 7), 1'b0, '0);
                random_sent++;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            $error("pixel_out: %0d expected results never came", expected_pixels.size());
            error_count++;
        end

        $display("Ran the directed table and random images with gaps: %0d requests sent,",
                 request_count);
        $display("%0d remapped pixels checked across %0d table builds.",
                 result_count, build_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
hdl/heq_pkg.sv
hdl/heq_div.sv
hdl/histogram_equalizer.sv
bench/tb_top.sv
